[sv/msgp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msgp_pkg
// Shared types and constants for the data-chunk message parser.
// ----------------------------------------------------------------------------
package msgp_pkg;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_t;

  // one input request as held in the input register
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       message_end;
  } msgp_item_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  payload_byte;
    logic        payload_start;
    logic [31:0] sequence_out;
    logic [31:0] data_length_out;
    logic        transfer_done;
    logic        last_result;
  } msgp_result_t;

  typedef struct packed {
    logic room;      // at least two free slots
    logic nonempty;
  } msgp_fifo_stat_t;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_LW    = 3;

  // MessagePack markers
  localparam logic [7:0] MK_FIXMAP  = 8'h80;
  localparam logic [7:0] MK_FIXSTR  = 8'ha0;
  localparam logic [7:0] MK_TRUE    = 8'hc3;
  localparam logic [7:0] MK_BIN8    = 8'hc4;
  localparam logic [7:0] MK_BIN16   = 8'hc5;
  localparam logic [7:0] MK_BIN32   = 8'hc6;
  localparam logic [7:0] MK_UINT8   = 8'hcc;
  localparam logic [7:0] MK_UINT16  = 8'hcd;
  localparam logic [7:0] MK_UINT32  = 8'hce;
  localparam logic [7:0] MK_STR8    = 8'hd9;

  localparam logic [7:0] NAME_DATA [4] = '{8'h64, 8'h61, 8'h74, 8'h61};
  localparam logic [7:0] NAME_DONE [4] = '{8'h64, 8'h6f, 8'h6e, 8'h65};

endpackage
`default_nettype wire

[sv/msgpack_data_chunk_parser_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msgpack_data_chunk_parser_unit
// Streaming parser for MessagePack data-chunk messages, one byte per request.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle while in_stall is low. Each request is
// registered in the input register, parsed once the result queue has room,
// and its results (a payload byte, an accept/reject report, or both) land in
// a four-entry result queue, whose head is shown on the out_ port.
// Results leave one per cycle while out_stall is low, so a request that ends
// a message while also carrying a payload byte yields two results in turn,
// and the input stalls while a request waits in the input register and fewer
// than two queue slots are free. Payload bytes sent before a reject are to be
// dropped by the consumer. LENGTH_WIDTH sets the widest bin length accepted.
module msgpack_data_chunk_parser_unit #(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_byte_present,
  input  logic        in_message_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_start,
  output logic [31:0] out_sequence_out,
  output logic [31:0] out_data_length_out,
  output logic        out_transfer_done,
  output logic        out_last_result
);
  import msgp_pkg::*;

  logic            stage_valid_r;
  msgp_item_t      stage_item_r;
  logic            fire;
  logic            pop;
  logic [1:0]      res_cnt;
  logic [1:0]      push_cnt;
  msgp_result_t    res0, res1, head;
  msgp_fifo_stat_t fifo_stat;

  assign fire     = stage_valid_r && fifo_stat.room;
  assign in_stall = stage_valid_r && !fifo_stat.room;
  assign push_cnt = fire ? res_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (!in_stall) begin
      stage_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_item_r.msg_byte     <= in_msg_byte;
      stage_item_r.byte_present <= in_byte_present;
      stage_item_r.message_end  <= in_message_end;
    end
  end

  msgp_parser #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (stage_item_r),
    .res0    (res0),
    .res1    (res1),
    .res_cnt (res_cnt)
  );

  msgp_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .push0    (res0),
    .push1    (res1),
    .pop      (pop),
    .head     (head),
    .stat     (fifo_stat)
  );

  assign out_valid           = fifo_stat.nonempty;
  assign pop                 = out_valid && !out_stall;
  assign out_result_kind     = head.result_kind;
  assign out_payload_byte    = head.payload_byte;
  assign out_payload_start   = head.payload_start;
  assign out_sequence_out    = head.sequence_out;
  assign out_data_length_out = head.data_length_out;
  assign out_transfer_done   = head.transfer_done;
  assign out_last_result     = head.last_result;

`ifndef NO_ASSERTIONS
  // two results from one request: payload byte first, then the report
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_cnt == 2'd2 |-> res0.result_kind == KIND_PAYLOAD &&
                                res1.result_kind != KIND_PAYLOAD)
    else $error("result pair out of order");

  // every message end produces a report
  a_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
    fire && stage_item_r.message_end |-> res_cnt != 2'd0)
    else $error("message end without report");

  // a report is always the final result of its request
  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != KIND_PAYLOAD |-> out_last_result)
    else $error("report not marked last");
`endif

endmodule
`default_nettype wire

[sv/msgp_result_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msgp_result_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module msgp_result_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               push_cnt,
  input  msgp_pkg::msgp_result_t   push0,
  input  msgp_pkg::msgp_result_t   push1,
  input  logic                     pop,
  output msgp_pkg::msgp_result_t   head,
  output msgp_pkg::msgp_fifo_stat_t stat
);
  import msgp_pkg::*;

  msgp_result_t        mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_LW-1:0]  level_r, level_nxt;
  logic [FIFO_AW-1:0]  wr_ptr_p1;

  assign wr_ptr_p1  = wr_ptr_r + FIFO_AW'(1);
  assign wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
  assign level_nxt  = level_r + FIFO_LW'(push_cnt) - FIFO_LW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push1;
    end
  end

  assign head          = mem_r[rd_ptr_r];
  assign stat.nonempty = (level_r != '0);
  assign stat.room     = (level_r <= FIFO_LW'(FIFO_DEPTH - 2));

endmodule
`default_nettype wire

[sv/msgp_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msgp_parser
// Parser state and per-byte next-state logic; builds up to two results.
// ----------------------------------------------------------------------------
module msgp_parser #(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  msgp_pkg::msgp_item_t   item,
  output msgp_pkg::msgp_result_t res0,
  output msgp_pkg::msgp_result_t res1,
  output logic [1:0]             res_cnt
);
  import msgp_pkg::*;

  typedef enum logic [3:0] {
    PH_MAP        = 4'd0,
    PH_KEY_HDR    = 4'd1,
    PH_KEY_BODY   = 4'd2,
    PH_DATA_MARK  = 4'd3,
    PH_DATA_LEN   = 4'd4,
    PH_DATA_BODY  = 4'd5,
    PH_DONE_VAL   = 4'd6,
    PH_SKIP_MARK  = 4'd7,
    PH_SKIP_BYTES = 4'd8,
    PH_STR8_LEN   = 4'd9,
    PH_TRAIL      = 4'd10,
    PH_FAULT      = 4'd11
  } phase_t;

  localparam int unsigned LW = LENGTH_WIDTH;

  phase_t          phase_r, phase_nxt;
  logic [3:0]      entries_r, entries_nxt;
  logic [4:0]      key_len_r, key_len_nxt;
  logic [4:0]      key_pos_r, key_pos_nxt;
  logic [1:0]      key_match_r, key_match_nxt;
  logic [LW-1:0]   bytes_left_r, bytes_left_nxt;
  logic [2:0]      len_bytes_r, len_bytes_nxt;
  logic [LW-1:0]   data_len_r, data_len_nxt;
  logic            done_seen_r, done_seen_nxt;
  logic [31:0]     seq_r, seq_nxt;

  logic [7:0]      b;
  logic [4:0]      key_pos_inc;
  logic [LW-1:0]   len_shift;
  logic [LW-1:0]   bytes_dec;
  logic            pay_v;
  logic            pay_start;
  logic            rep_ok;
  msgp_result_t    pay_res;
  msgp_result_t    rep_res;

  function automatic phase_t value_done(input logic [3:0] entries);
    return (entries == 4'd0) ? PH_TRAIL : PH_KEY_HDR;
  endfunction

  function automatic phase_t value_phase(input logic [1:0] km);
    if (km[0]) return PH_DATA_MARK;
    else if (km[1]) return PH_DONE_VAL;
    else return PH_SKIP_MARK;
  endfunction

  assign b           = item.msg_byte;
  assign key_pos_inc = key_pos_r + 5'd1;
  assign len_shift   = {bytes_left_r[LW-9:0], b};
  assign bytes_dec   = bytes_left_r - LW'(1);

  always_comb begin
    phase_nxt      = phase_r;
    entries_nxt    = entries_r;
    key_len_nxt    = key_len_r;
    key_pos_nxt    = key_pos_r;
    key_match_nxt  = key_match_r;
    bytes_left_nxt = bytes_left_r;
    len_bytes_nxt  = len_bytes_r;
    data_len_nxt   = data_len_r;
    done_seen_nxt  = done_seen_r;
    seq_nxt        = seq_r;
    pay_v          = 1'b0;
    pay_start      = 1'b0;

    if (item.byte_present) begin
      if (phase_r == PH_MAP) begin
        data_len_nxt  = '0;
        done_seen_nxt = 1'b0;
      end
      case (phase_r)
        PH_MAP: begin
          if ((b & 8'hf0) == MK_FIXMAP) begin
            entries_nxt = b[3:0];
            phase_nxt   = value_done(b[3:0]);
          end else begin
            phase_nxt = PH_FAULT;
          end
        end
        PH_KEY_HDR: begin
          if ((b & 8'he0) != MK_FIXSTR) begin
            phase_nxt = PH_FAULT;
          end else begin
            entries_nxt   = entries_r - 4'd1;
            key_len_nxt   = b[4:0];
            key_pos_nxt   = '0;
            key_match_nxt = (b[4:0] == 5'd4) ? 2'b11 : 2'b00;
            phase_nxt     = (b[4:0] == 5'd0) ? value_phase(2'b00) : PH_KEY_BODY;
          end
        end
        PH_KEY_BODY: begin
          if (key_pos_r < 5'd4) begin
            if (b != NAME_DATA[key_pos_r[1:0]]) key_match_nxt[0] = 1'b0;
            if (b != NAME_DONE[key_pos_r[1:0]]) key_match_nxt[1] = 1'b0;
          end
          key_pos_nxt = key_pos_inc;
          if (key_pos_inc >= key_len_r) phase_nxt = value_phase(key_match_nxt);
        end
        PH_DATA_MARK: begin
          bytes_left_nxt = '0;
          phase_nxt      = PH_DATA_LEN;
          case (b)
            MK_BIN8:  len_bytes_nxt = 3'd1;
            MK_BIN16: len_bytes_nxt = 3'd2;
            MK_BIN32: len_bytes_nxt = 3'd4;
            default:  phase_nxt     = PH_FAULT;
          endcase
        end
        PH_DATA_LEN: begin
          // length must still fit after shifting in another byte
          if (bytes_left_r[LW-1 -: 8] != 8'd0) begin
            phase_nxt = PH_FAULT;
          end else begin
            bytes_left_nxt = len_shift;
            len_bytes_nxt  = len_bytes_r - 3'd1;
            if (len_bytes_r == 3'd1) begin
              data_len_nxt = len_shift;
              phase_nxt    = (len_shift == '0) ? value_done(entries_r) : PH_DATA_BODY;
            end
          end
        end
        PH_DATA_BODY: begin
          pay_v          = 1'b1;
          pay_start      = (bytes_left_r == data_len_r);
          bytes_left_nxt = bytes_dec;
          if (bytes_dec == '0) phase_nxt = value_done(entries_r);
        end
        PH_DONE_VAL: begin
          done_seen_nxt = (b == MK_TRUE);
          phase_nxt     = value_done(entries_r);
        end
        PH_SKIP_MARK: begin
          if (b == MK_UINT8) begin
            bytes_left_nxt = LW'(1);
            phase_nxt      = PH_SKIP_BYTES;
          end else if (b == MK_UINT16) begin
            bytes_left_nxt = LW'(2);
            phase_nxt      = PH_SKIP_BYTES;
          end else if (b == MK_UINT32) begin
            bytes_left_nxt = LW'(4);
            phase_nxt      = PH_SKIP_BYTES;
          end else if ((b & 8'he0) == MK_FIXSTR) begin
            bytes_left_nxt = LW'(b[4:0]);
            phase_nxt      = (b[4:0] == 5'd0) ? value_done(entries_r) : PH_SKIP_BYTES;
          end else if (b == MK_STR8) begin
            phase_nxt = PH_STR8_LEN;
          end else begin
            phase_nxt = value_done(entries_r);
          end
        end
        PH_STR8_LEN: begin
          bytes_left_nxt = LW'(b);
          phase_nxt      = (b == 8'd0) ? value_done(entries_r) : PH_SKIP_BYTES;
        end
        PH_SKIP_BYTES: begin
          bytes_left_nxt = bytes_dec;
          if (bytes_dec == '0) phase_nxt = value_done(entries_r);
        end
        default: begin
        end
      endcase
    end

    // a skip still running on the final entry counts as complete
    rep_ok = (phase_nxt == PH_TRAIL) ||
             (phase_nxt == PH_SKIP_BYTES && entries_nxt == 4'd0);

    pay_res                 = '0;
    pay_res.result_kind     = KIND_PAYLOAD;
    pay_res.payload_byte    = b;
    pay_res.payload_start   = pay_start;
    pay_res.last_result     = !item.message_end;

    rep_res                 = '0;
    rep_res.result_kind     = rep_ok ? KIND_ACCEPT : KIND_REJECT;
    rep_res.sequence_out    = seq_r;
    rep_res.data_length_out = rep_ok ? 32'(data_len_nxt) : 32'd0;
    rep_res.transfer_done   = rep_ok && done_seen_nxt;
    rep_res.last_result     = 1'b1;

    if (item.message_end) begin
      seq_nxt        = (rep_ok && !done_seen_nxt) ? seq_r + 32'd1 : 32'd0;
      phase_nxt      = PH_MAP;
      entries_nxt    = '0;
      key_len_nxt    = '0;
      key_pos_nxt    = '0;
      key_match_nxt  = '0;
      bytes_left_nxt = '0;
      len_bytes_nxt  = '0;
      data_len_nxt   = '0;
      done_seen_nxt  = 1'b0;
    end
  end

  assign res0    = pay_v ? pay_res : rep_res;
  assign res1    = rep_res;
  assign res_cnt = 2'(pay_v) + 2'(item.message_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_MAP;
      entries_r    <= '0;
      key_len_r    <= '0;
      key_pos_r    <= '0;
      key_match_r  <= '0;
      bytes_left_r <= '0;
      len_bytes_r  <= '0;
      data_len_r   <= '0;
      done_seen_r  <= 1'b0;
      seq_r        <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      entries_r    <= entries_nxt;
      key_len_r    <= key_len_nxt;
      key_pos_r    <= key_pos_nxt;
      key_match_r  <= key_match_nxt;
      bytes_left_r <= bytes_left_nxt;
      len_bytes_r  <= len_bytes_nxt;
      data_len_r   <= data_len_nxt;
      done_seen_r  <= done_seen_nxt;
      seq_r        <= seq_nxt;
    end
  end

endmodule
`default_nettype wire
